FILE: design/fgn_pkg.sv
// ----------------------------------------------------------------------------
// fgn_pkg: shared types and constants for the fractal gradient noise block
// Sequencer state and micro-step codes, request and register codes.
// ----------------------------------------------------------------------------
package fgn_pkg;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam logic [1:0] CFG_OCTAVES = 2'd0;
    localparam logic [1:0] CFG_PERSIST = 2'd1;
    localparam logic [1:0] CFG_LACUN   = 2'd2;

    localparam logic [3:0]  OCT_RESET     = 4'd4;
    localparam logic [15:0] PERSIST_RESET = 16'd32768;
    localparam logic [15:0] LACUN_RESET   = 16'd8192;

    localparam logic [35:0] FREQ_ONE = 36'd4096;
    localparam logic [16:0] AMP_ONE  = 17'd65536;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_OCT  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    // micro-steps of one octave; each step issues at most one product
    typedef enum logic [4:0] {
        K_XLO  = 5'd0,
        K_XHI  = 5'd1,
        K_YLO  = 5'd2,
        K_YHI  = 5'd3,
        K_TXSQ = 5'd4,
        K_TXCU = 5'd5,
        K_EXM  = 5'd6,
        K_TYSQ = 5'd7,
        K_TYCU = 5'd8,
        K_EYM  = 5'd9,
        K_BL0  = 5'd10,
        K_BL1  = 5'd11,
        K_R1   = 5'd12,
        K_BLY  = 5'd13,
        K_WGT  = 5'd14,
        K_AMP  = 5'd15,
        K_FLO  = 5'd16,
        K_FHI  = 5'd17,
        K_FNX  = 5'd18
    } t_step;

endpackage

FILE: design/fractal_gradient_noise_2d.sv
// One request at a time: new requests stall while an evaluation runs through the
//   octave loop, the divider and the output register. The sum is
//   SUM_W = 37 + clog2(MAX_OCTAVES + 1) bits wide, 41 by default.
// The shared 25x22 multiplier and the single table read port set the pace of the
//   octave loop, the bit-serial divider that of the tail.
// Synchronous active-low reset clears control and configuration, not the table.
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d: 2D gradient noise summed over octaves
// Sequenced datapath with one shared multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_2d
    import fgn_pkg::*;
#(
    parameter int TABLE_SIZE  = 256,
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_table_value,
    input  logic [23:0]        i_x_coord,
    input  logic [23:0]        i_y_coord,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_noise_value,
    output logic [7:0]         o_pixel_intensity,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int IW   = $clog2(TABLE_SIZE);
    localparam int OW   = $clog2(MAX_OCTAVES + 1);
    localparam int WW   = 17 + $clog2(MAX_OCTAVES + 1);
    localparam int SW   = 37 + $clog2(MAX_OCTAVES + 1);
    localparam int RW   = WW + 2;
    localparam int DCW  = $clog2(SW + 1);

    // table index arithmetic wraps modulo the (power of two) table size
    function automatic logic [IW-1:0] wrap_add(input logic [7:0] p,
                                               input logic [IW-1:0] j,
                                               input logic one);
        logic [IW+8:0] s;
        s = (IW+9)'(p) + (IW+9)'(j) + (IW+9)'(one);
        return s[IW-1:0];
    endfunction

    function automatic logic signed [19:0] corner_dot(input logic [3:0] h,
                                                      input logic signed [17:0] gx,
                                                      input logic signed [17:0] gy);
        logic signed [19:0] u;
        logic signed [19:0] v;
        u = h[3] ? 20'(gy) : 20'(gx);
        v = h[3] ? 20'(gx) : 20'(gy);
        if (h[0]) begin
            u = -u;
        end
        if (h[1]) begin
            v = -v;
        end
        return u + v;
    endfunction

    t_state r_state;
    t_step  r_step;

    logic [3:0]  r_octave_count;
    logic [15:0] r_persistence_q;
    logic [15:0] r_lacunarity_q;

    logic [23:0]  r_x, r_y;
    logic [35:0]  r_freq;
    logic [16:0]  r_amp;
    logic [WW-1:0] r_wsum;
    logic signed [SW-1:0] r_sum;
    logic [OW-1:0] r_oct_left;

    logic [41:0]   r_acc;
    logic [IW-1:0] r_xi, r_yi;
    logic [15:0]   r_tx, r_ty, r_t2;
    logic [16:0]   r_ex, r_ey;
    logic [7:0]    r_p0, r_p1;
    logic [3:0]    r_haa, r_hab, r_hba, r_hbb;
    logic signed [19:0] r_r0, r_r1;

    logic signed [46:0] r_prod;
    logic signed [24:0] m_a;
    logic signed [21:0] m_b;

    logic [SW-1:0]  r_dvd;
    logic [RW-1:0]  r_rem;
    logic [DCW-1:0] r_dcnt;
    logic           r_neg;

    logic               r_out_valid;
    logic signed [15:0] r_noise;
    logic [7:0]         r_pix;

    logic          in_acc;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    fgn_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_SIZE)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_table_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign ram_we     = in_acc && (i_req_type == REQ_LOAD);
    assign ram_waddr  = wrap_add(i_table_index, '0, 1'b0);
    assign o_cfg_ready = 1'b1;

    // octaves clamped to one..MAX_OCTAVES
    logic [OW-1:0] oct_init;
    always_comb begin
        if (r_octave_count == 4'd0) begin
            oct_init = OW'(1);
        end else if (32'(r_octave_count) > MAX_OCTAVES) begin
            oct_init = OW'(MAX_OCTAVES);
        end else begin
            oct_init = OW'(r_octave_count);
        end
    end

    // recombine two partial products: acc + (prod << 18)
    logic [59:0] fsum;
    assign fsum = 60'(r_acc) + {r_prod[41:0], 18'd0};

    logic [IW-1:0]        s_idx;
    logic [FRAC_BITS-1:0] s_frac;
    logic [FRAC_BITS+15:0] s_tmp;
    logic [15:0]          s_t;
    assign s_idx  = fsum[FRAC_BITS+IW+11:FRAC_BITS+12];
    assign s_frac = fsum[FRAC_BITS+11:12];
    assign s_tmp  = {s_frac, 16'd0} >> FRAC_BITS;
    assign s_t    = s_tmp[15:0];

    logic [47:0] nf;
    logic [35:0] nf_sat;
    assign nf     = fsum[59:12];
    assign nf_sat = (|nf[47:36]) ? '1 : nf[35:0];

    // quintic ease inner term 6*t2 - 15*t + 10, clamped at zero
    logic [15:0]        e_t;
    logic signed [22:0] inner_s;
    logic [20:0]        inner;
    assign e_t     = (r_step == K_EYM) ? r_ty : r_tx;
    assign inner_s = 23'sd655360 + $signed({5'd0, r_t2, 2'b0}) + $signed({6'd0, r_t2, 1'b0})
                   - $signed({3'd0, e_t, 4'b0}) + $signed({7'd0, e_t});
    assign inner   = inner_s[22] ? '0 : inner_s[20:0];

    logic signed [17:0] gx0, gx1, gy0, gy1;
    logic signed [19:0] g_aa, g_ba, g_ab, g_bb;
    logic signed [20:0] d_bl;
    logic signed [19:0] q_bl;
    logic signed [19:0] n_oct;
    assign gx0  = $signed({2'b00, r_tx});
    assign gx1  = $signed({2'b11, r_tx});
    assign gy0  = $signed({2'b00, r_ty});
    assign gy1  = $signed({2'b11, r_ty});
    assign g_aa = corner_dot(r_haa, gx0, gy0);
    assign g_ba = corner_dot(r_hba, gx1, gy0);
    assign g_ab = corner_dot(r_hab, gx0, gy1);
    assign g_bb = corner_dot(r_hbb, gx1, gy1);
    assign q_bl = $signed(r_prod[35:16]);
    assign n_oct = r_r0 + q_bl;

    always_comb begin
        case (r_step)
            K_BL0:   d_bl = 21'(g_ba) - 21'(g_aa);
            K_BL1:   d_bl = 21'(g_bb) - 21'(g_ab);
            default: d_bl = 21'(r_r1) - 21'(r_r0);
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        m_a = '0;
        m_b = '0;
        ram_raddr = r_xi;
        if (r_state == S_OCT) begin
            case (r_step)
                K_XLO: begin
                    m_a = $signed({1'b0, r_x});
                    m_b = $signed({4'd0, r_freq[17:0]});
                end
                K_XHI: begin
                    m_a = $signed({1'b0, r_x});
                    m_b = $signed({4'd0, r_freq[35:18]});
                end
                K_YLO: begin
                    m_a = $signed({1'b0, r_y});
                    m_b = $signed({4'd0, r_freq[17:0]});
                end
                K_YHI: begin
                    m_a = $signed({1'b0, r_y});
                    m_b = $signed({4'd0, r_freq[35:18]});
                    ram_raddr = r_xi;
                end
                K_TXSQ: begin
                    m_a = $signed({9'd0, r_tx});
                    m_b = $signed({6'd0, r_tx});
                    ram_raddr = wrap_add(8'd0, r_xi, 1'b1);
                end
                K_TXCU: begin
                    m_a = $signed({9'd0, r_tx});
                    m_b = $signed({6'd0, r_prod[31:16]});
                    ram_raddr = wrap_add(r_p0, r_yi, 1'b0);
                end
                K_EXM: begin
                    m_a = $signed({9'd0, r_prod[31:16]});
                    m_b = $signed({1'b0, inner});
                    ram_raddr = wrap_add(r_p0, r_yi, 1'b1);
                end
                K_TYSQ: begin
                    m_a = $signed({9'd0, r_ty});
                    m_b = $signed({6'd0, r_ty});
                    ram_raddr = wrap_add(r_p1, r_yi, 1'b0);
                end
                K_TYCU: begin
                    m_a = $signed({9'd0, r_ty});
                    m_b = $signed({6'd0, r_prod[31:16]});
                    ram_raddr = wrap_add(r_p1, r_yi, 1'b1);
                end
                K_EYM: begin
                    m_a = $signed({9'd0, r_prod[31:16]});
                    m_b = $signed({1'b0, inner});
                end
                K_BL0, K_BL1: begin
                    m_a = 25'(d_bl);
                    m_b = $signed({5'd0, r_ex});
                end
                K_BLY: begin
                    m_a = 25'(d_bl);
                    m_b = $signed({5'd0, r_ey});
                end
                K_WGT: begin
                    m_a = 25'(n_oct);
                    m_b = $signed({5'd0, r_amp});
                end
                K_AMP: begin
                    m_a = $signed({8'd0, r_amp});
                    m_b = $signed({6'd0, r_persistence_q});
                end
                K_FLO: begin
                    m_a = $signed({7'd0, r_freq[17:0]});
                    m_b = $signed({6'd0, r_lacunarity_q});
                end
                K_FHI: begin
                    m_a = $signed({7'd0, r_freq[35:18]});
                    m_b = $signed({6'd0, r_lacunarity_q});
                end
                default: begin
                    m_a = '0;
                    m_b = '0;
                end
            endcase
        end
    end

    // divider step and final formatting
    logic [RW-1:0] rem_sh;
    logic [RW:0]   rem_sub;
    assign rem_sh  = {r_rem[RW-2:0], r_dvd[SW-1]};
    assign rem_sub = {1'b0, rem_sh} - {2'b0, r_wsum, 1'b0};

    logic signed [15:0] q16;
    logic [15:0]        q_mag;
    logic [15:0]        v16;
    logic [23:0]        pix_w;
    assign q_mag = r_dvd[15:0];
    always_comb begin
        if (!r_neg && (r_dvd > SW'(32767))) begin
            q16 = 16'sh7FFF;
        end else if (r_neg && (r_dvd > SW'(32768))) begin
            q16 = 16'sh8000;
        end else if (r_neg) begin
            q16 = $signed(-q_mag);
        end else begin
            q16 = $signed(q_mag);
        end
    end
    assign v16   = q16 ^ 16'h8000;
    assign pix_w = {v16, 8'd0} - 24'(v16);

    logic [SW-1:0] sum_mag;
    assign sum_mag = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count  <= OCT_RESET;
            r_persistence_q <= PERSIST_RESET;
            r_lacunarity_q  <= LACUN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OCTAVES: r_octave_count  <= i_cfg_data[3:0];
                CFG_PERSIST: r_persistence_q <= i_cfg_data;
                CFG_LACUN:   r_lacunarity_q  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= K_XLO;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_req_type == REQ_EVAL)) begin
                        r_state <= S_OCT;
                        r_step  <= K_XLO;
                    end
                end
                S_OCT: begin
                    if (r_step == K_FNX) begin
                        r_step <= K_XLO;
                        if (r_oct_left == OW'(1)) begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_step <= t_step'(r_step + 5'd1);
                    end
                end
                S_DIV: begin
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        case (r_state)
            S_IDLE: begin
                r_x        <= i_x_coord;
                r_y        <= i_y_coord;
                r_freq     <= FREQ_ONE;
                r_amp      <= AMP_ONE;
                r_wsum     <= '0;
                r_sum      <= '0;
                r_oct_left <= oct_init;
            end
            S_OCT: begin
                case (r_step)
                    K_XHI, K_YHI, K_FHI: r_acc <= r_prod[41:0];
                    K_YLO: begin
                        r_xi <= s_idx;
                        r_tx <= s_t;
                    end
                    K_TXSQ: begin
                        r_yi <= s_idx;
                        r_ty <= s_t;
                        r_p0 <= ram_rdata;
                    end
                    K_TXCU: begin
                        r_p1 <= ram_rdata;
                        r_t2 <= r_prod[31:16];
                    end
                    K_EXM:  r_haa <= ram_rdata[3:0];
                    K_TYSQ: begin
                        r_hab <= ram_rdata[3:0];
                        r_ex  <= r_prod[32:16];
                    end
                    K_TYCU: begin
                        r_hba <= ram_rdata[3:0];
                        r_t2  <= r_prod[31:16];
                    end
                    K_EYM:  r_hbb <= ram_rdata[3:0];
                    K_BL0:  r_ey  <= r_prod[32:16];
                    K_BL1:  r_r0  <= g_aa + q_bl;
                    K_R1:   r_r1  <= g_ab + q_bl;
                    K_AMP: begin
                        r_sum  <= r_sum + SW'(r_prod);
                        r_wsum <= r_wsum + WW'(r_amp);
                    end
                    K_FLO:  r_amp <= r_prod[32:16];
                    K_FNX: begin
                        r_freq     <= nf_sat;
                        r_oct_left <= r_oct_left - OW'(1);
                        r_dvd      <= sum_mag;
                        r_rem      <= '0;
                        r_dcnt     <= DCW'(SW);
                        r_neg      <= r_sum[SW-1];
                    end
                    default: ;
                endcase
                // K_BLY result lands in r_prod; K_WGT consumes it via n_oct
            end
            S_DIV: begin
                r_dvd  <= {r_dvd[SW-2:0], ~rem_sub[RW]};
                r_rem  <= rem_sub[RW] ? rem_sh : rem_sub[RW-1:0];
                r_dcnt <= r_dcnt - DCW'(1);
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_noise <= q16;
                    r_pix   <= pix_w[23:16];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_noise_value     = r_noise;
    assign o_pixel_intensity = r_pix;

endmodule

FILE: design/fgn_ram.sv
// ----------------------------------------------------------------------------
// fgn_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fgn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fractal_gradient_noise_2d
// Loads a shuffled permutation table, then evaluates points over a range of
// octave, persistence and lacunarity settings. A scoreboard predicts every
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fgn_pkg::*;

    typedef struct {
        logic signed [15:0] noise;
        logic [7:0]         pixel;
    } t_noise_result;

    class noise_scoreboard;
        logic [7:0]    perm [256];
        logic [3:0]    octaves;
        logic [15:0]   persist;
        logic [15:0]   lacun;
        t_noise_result pending [$];
        int            mismatches;
        int            loads;
        int            evals;

        function void reset_state();
            octaves = OCT_RESET;
            persist = PERSIST_RESET;
            lacun   = LACUN_RESET;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_OCTAVES: octaves = data[3:0];
                CFG_PERSIST: persist = data;
                CFG_LACUN:   lacun   = data;
                default: ;
            endcase
        endfunction

        function longint ease(longint t);
            longint t2, t3, inner;
            t2 = (t * t) >>> 16;
            t3 = (t2 * t) >>> 16;
            inner = 6 * t2 + 10 * 65536 - 15 * t;
            if (inner < 0) inner = 0;
            return (t3 * inner) >>> 16;
        endfunction

        // floor of the weighted step: arithmetic shift rounds down
        function longint blend(longint a, longint b, longint e);
            return a + (((b - a) * e) >>> 16);
        endfunction

        function longint grad(logic [7:0] h, longint gx, longint gy);
            longint u, v;
            u = (h[3] == 1'b0) ? gx : gy;
            v = (h[3] == 1'b0) ? gy : gx;
            return (h[0] ? -u : u) + (h[1] ? -v : v);
        endfunction

        function longint octave_value(longint unsigned sx, longint unsigned sy);
            logic [7:0] xi, yi, p0, p1, haa, hab, hba, hbb;
            longint tx, ty, ex, ey, r0, r1;
            xi = sx[23:16];
            yi = sy[23:16];
            tx = longint'(sx[15:0]);
            ty = longint'(sy[15:0]);
            ex = ease(tx);
            ey = ease(ty);
            p0 = perm[xi];
            p1 = perm[8'(xi + 8'd1)];
            haa = perm[8'(p0 + yi)];
            hab = perm[8'(p0 + yi + 8'd1)];
            hba = perm[8'(p1 + yi)];
            hbb = perm[8'(p1 + yi + 8'd1)];
            r0 = blend(grad(haa, tx, ty), grad(hba, tx - 65536, ty), ex);
            r1 = blend(grad(hab, tx, ty - 65536), grad(hbb, tx - 65536, ty - 65536), ex);
            return blend(r0, r1, ey);
        endfunction

        function t_noise_result fbm_noise(logic [23:0] x, logic [23:0] y);
            longint unsigned freq, amp, wsum, nf;
            longint          acc, q;
            int              n_oct;
            t_noise_result   r;
            n_oct = (octaves == 0) ? 1 : (octaves > 8) ? 8 : octaves;
            freq = 4096;
            amp  = 65536;
            wsum = 0;
            acc  = 0;
            for (int i = 0; i < n_oct; i++) begin
                acc  += octave_value((longint'(x) * freq) >> 12,
                                     (longint'(y) * freq) >> 12) * longint'(amp);
                wsum += amp;
                amp  = (amp * persist) >> 16;
                nf   = (freq * lacun) >> 12;
                freq = (nf > 64'hF_FFFF_FFFF) ? 64'hF_FFFF_FFFF : nf;
            end
            q = acc / longint'(2 * wsum);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            r.noise = q[15:0];
            r.pixel = 8'(((q + 32768) * 255) >>> 16);
            return r;
        endfunction

        function void note_request(logic kind, logic [7:0] idx, logic [7:0] val,
                                   logic [23:0] x, logic [23:0] y);
            if (kind == REQ_LOAD) begin
                perm[idx] = val;
                loads++;
            end else begin
                pending.push_back(fbm_noise(x, y));
                evals++;
            end
        endfunction

        function void check_result(logic signed [15:0] noise, logic [7:0] pixel);
            t_noise_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result noise=%0d pixel=%0d", noise, pixel);
                return;
            end
            want = pending.pop_front();
            if (want.noise !== noise || want.pixel !== pixel) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: noise exp %0d got %0d, pixel exp %0d got %0d",
                             want.noise, noise, want.pixel, pixel);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_req_type;
    logic [7:0]         i_table_index;
    logic [7:0]         i_table_value;
    logic [23:0]        i_x_coord;
    logic [23:0]        i_y_coord;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_noise_value;
    logic [7:0]         o_pixel_intensity;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    noise_scoreboard sb;
    bit              idling;
    int              settings;

    fractal_gradient_noise_2d dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver stalls in bursts
    initial begin
        int burst;
        burst = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (burst == 0 && idling && $urandom_range(0, 7) == 0)
                burst = $urandom_range(1, 15);
            i_out_stall = (burst > 0);
            if (burst > 0) burst--;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_noise_value, o_pixel_intensity);

    task send_request(logic kind, logic [7:0] idx, logic [7:0] val,
                      logic [23:0] x, logic [23:0] y);
        if (idling && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_req_type    = kind;
        i_table_index = idx;
        i_table_value = val;
        i_x_coord     = x;
        i_y_coord     = y;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(kind, idx, val, x, y);
        @(negedge i_clk);
    endtask

    task eval_point(logic [23:0] x, logic [23:0] y);
        send_request(REQ_EVAL, 8'($urandom), 8'($urandom), x, y);
    endtask

    task load_entry(logic [7:0] idx, logic [7:0] val);
        send_request(REQ_LOAD, idx, val, 24'($urandom), 24'($urandom));
    endtask

    task write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // hold off until every result is back and the block has gone quiet
    task drain();
        i_in_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    task configure(logic [3:0] oct, logic [15:0] pers, logic [15:0] lac);
        drain();
        write_reg(CFG_OCTAVES, {12'($urandom), oct});
        write_reg(CFG_PERSIST, pers);
        write_reg(CFG_LACUN, lac);
        settings++;
    endtask

    function logic [23:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return 24'($urandom_range(0, 24'h03FFFF));
            1:       return {8'($urandom), 16'hFFFF};
            default: return 24'($urandom);
        endcase
    endfunction

    task random_traffic(int count);
        for (int i = 0; i < count; i++)
            if ($urandom_range(0, 4) == 0)
                load_entry(8'($urandom), 8'($urandom));
            else
                eval_point(rand_coord(), rand_coord());
    endtask

    task corner_points();
        eval_point(24'h000000, 24'h000000);
        eval_point(24'hFFFFFF, 24'hFFFFFF);
        eval_point(24'h00FFFF, 24'h000000);
        eval_point(24'h000000, 24'h00FFFF);
        eval_point(24'h010000, 24'hFF0000);
        eval_point(24'h7F8000, 24'h808000);
    endtask

    initial begin
        logic [7:0] shuffle [256];
        logic [7:0] tmp;
        int         j;
        sb = new();
        sb.reset_state();
        idling        = 1'b1;
        settings      = 1;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_LOAD;
        i_table_index = '0;
        i_table_value = '0;
        i_x_coord     = '0;
        i_y_coord     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_OCTAVES;
        i_cfg_data    = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill every entry with a shuffled permutation before any evaluation
        for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
        for (int i = 255; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = shuffle[i];
            shuffle[i] = shuffle[j];
            shuffle[j] = tmp;
        end
        for (int i = 0; i < 256; i++) load_entry(8'(i), shuffle[i]);

        // reset settings, extremes of the table fields and coordinates
        corner_points();
        load_entry(8'h00, 8'hFF);
        load_entry(8'hFF, 8'h00);
        load_entry(8'h80, 8'h7F);
        corner_points();

        // single octave, zero weights and frequency factor
        configure(4'd1, 16'd0, 16'd0);
        corner_points();
        random_traffic(30);
        // widest octave count, maximum factors: frequency saturates
        configure(4'd8, 16'hFFFF, 16'hFFFF);
        corner_points();
        random_traffic(30);
        // zero octaves acts as one
        configure(4'd0, 16'd40000, 16'd12000);
        corner_points();
        random_traffic(30);
        // oversized octave count clamps
        configure(4'd15, 16'd20000, 16'd4096);
        corner_points();
        random_traffic(30);

        for (int p = 0; p < 6; p++) begin
            configure(4'($urandom_range(1, 8)), 16'($urandom), 16'($urandom_range(0, 16384)));
            if (p == 5) idling = 1'b0;
            random_traffic(150);
        end

        drain();
        $display("Covered %0d table loads and %0d evaluations over %0d register settings",
                 sb.loads, sb.evals, settings);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
design/fgn_pkg.sv
design/fgn_ram.sv
design/fractal_gradient_noise_2d.sv
bench/testbench.sv
